[hw/rtl/sacl_pkg.sv]
// shared types, constants and register codes for the set-associative cache lookup
package sacl_pkg;

   // default sizes
   localparam int MAX_WAYS_DEF  = 8;
   localparam int MAX_SETS_DEF  = 256;   // set count is a power of two
   localparam int ADDR_BITS_DEF = 16;

   // recency stamp width
   localparam int STAMP_W = 32;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY      = 2'd3;

   // register reset values
   localparam logic [3:0] OFFSET_BITS_RST = 4'd2;
   localparam logic [3:0] SET_BITS_RST    = 4'd2;
   localparam logic [3:0] WAYS_IN_USE_RST = 4'd2;
   localparam logic       POLICY_RST      = 1'b0;

   // replacement policy codes
   localparam logic POLICY_LRU  = 1'b0;
   localparam logic POLICY_FIFO = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOOK,
      ST_SCAN,
      ST_WRITE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic req_ready;
      logic capture;
      logic clr_wr;
      logic rd_en;
      logic look;
      logic scan_step;
      logic wr_en;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic need_scan;
      logic scan_last;
      logic rsp_free;
   } sts_type;

endpackage

[hw/rtl/sacl_if.sv]
// request and response channel interfaces

interface sacl_req_if #(parameter int ADDR_W = 16);
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface sacl_rsp_if #(parameter int ADDR_W = 16, parameter int SET_W = 8,
                        parameter int WAY_W = 3);
   logic              valid;
   logic              ready;
   logic              hit;
   logic [ADDR_W-1:0] block_number;
   logic [SET_W-1:0]  set_index;
   logic [WAY_W-1:0]  way;

   modport source (output valid, output hit, output block_number, output set_index,
                   output way, input ready);
   modport sink   (input valid, input hit, input block_number, input set_index,
                   input way, output ready);
endinterface

[hw/rtl/sacl_ctrl.sv]
// controller state machine of the cache lookup
module sacl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  sacl_pkg::sts_type sts,
   output sacl_pkg::cmd_type cmd
);

   sacl_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sacl_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sacl_pkg::ST_CLEAR: begin
            if (sts.clr_last) state_in = sacl_pkg::ST_IDLE;
         end
         sacl_pkg::ST_IDLE: begin
            if (req_valid) state_in = sacl_pkg::ST_READ;
         end
         sacl_pkg::ST_READ: begin
            state_in = sacl_pkg::ST_LOOK;
         end
         sacl_pkg::ST_LOOK: begin
            state_in = sts.need_scan ? sacl_pkg::ST_SCAN : sacl_pkg::ST_WRITE;
         end
         sacl_pkg::ST_SCAN: begin
            if (sts.scan_last) state_in = sacl_pkg::ST_WRITE;
         end
         sacl_pkg::ST_WRITE: begin
            if (sts.rsp_free) state_in = sacl_pkg::ST_IDLE;
         end
         default: begin
            state_in = sacl_pkg::ST_CLEAR;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         sacl_pkg::ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
         end
         sacl_pkg::ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.capture   = req_valid;
         end
         sacl_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
         end
         sacl_pkg::ST_LOOK: begin
            cmd.look = 1'b1;
         end
         sacl_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         sacl_pkg::ST_WRITE: begin
            cmd.wr_en = sts.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[hw/rtl/sacl_dp.sv]
// datapath: config registers, set memory, tag compare, lru scan and result register
module sacl_dp #(
   parameter int MAX_WAYS  = sacl_pkg::MAX_WAYS_DEF,
   parameter int MAX_SETS  = sacl_pkg::MAX_SETS_DEF,
   parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF,
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
   localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sacl_pkg::cmd_type               cmd,
   output sacl_pkg::sts_type               sts,
   input  logic [ADDR_BITS-1:0]            req_address,
   input  logic                            csr_we,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_hit,
   output logic [ADDR_BITS-1:0]            rsp_block_number,
   output logic [SET_W-1:0]                rsp_set_index,
   output logic [WAY_W-1:0]                rsp_way
);

   localparam int STAMP_W = sacl_pkg::STAMP_W;
   localparam int WC_W    = $clog2(MAX_WAYS + 1);
   // row layout: valid bits, blocks, stamps, fifo pointer
   localparam int BLK_LO  = MAX_WAYS;
   localparam int STP_LO  = BLK_LO + MAX_WAYS * ADDR_BITS;
   localparam int FIFO_LO = STP_LO + MAX_WAYS * STAMP_W;
   localparam int ROW_W   = FIFO_LO + WAY_W;

   logic [3:0] offset_ff, set_bits_ff, ways_ff;
   logic       policy_ff;
   logic [WC_W-1:0] ways_act;
   logic [4:0]      wcfg5;

   logic [ADDR_BITS-1:0] block_in, block_ff;
   logic [SET_W-1:0]     set_msk, set_ff;
   logic [SET_W-1:0]     clr_ff;

   logic [ROW_W-1:0] mem [MAX_SETS];
   logic [ROW_W-1:0] row_ff, row_new;

   logic             hit_c, emp_c;
   logic [WAY_W-1:0] hit_way_c, emp_way_c, fifo_ptr, fifo_way_c, fifo_nxt_c;
   logic             hit_ff, emp_ff;
   logic [WAY_W-1:0] hit_way_ff, emp_way_ff, fifo_way_ff, fifo_nxt_ff;

   logic [WAY_W-1:0]   scan_ff, best_way_ff, way_sel;
   logic [STAMP_W-1:0] best_age_ff, age;
   logic [STAMP_W-1:0] count_ff;

   logic rsp_valid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= sacl_pkg::OFFSET_BITS_RST;
         set_bits_ff <= sacl_pkg::SET_BITS_RST;
         ways_ff     <= sacl_pkg::WAYS_IN_USE_RST;
         policy_ff   <= sacl_pkg::POLICY_RST;
      end else if (csr_we) begin
         case (csr_index)
            sacl_pkg::CSR_OFFSET_BITS: offset_ff   <= csr_wdata;
            sacl_pkg::CSR_SET_BITS:    set_bits_ff <= csr_wdata;
            sacl_pkg::CSR_WAYS_IN_USE: ways_ff     <= csr_wdata;
            sacl_pkg::CSR_POLICY:      policy_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ways in use, zero reads as one, saturated at the maximum
   always_comb begin
      wcfg5 = {1'b0, ways_ff};
      if (wcfg5 == 5'd0) begin
         ways_act = WC_W'(1);
      end else if (wcfg5 > 5'(MAX_WAYS)) begin
         ways_act = WC_W'(MAX_WAYS);
      end else begin
         ways_act = WC_W'(wcfg5);
      end
   end

   // block number and set index of the incoming address
   always_comb begin
      block_in = req_address >> offset_ff;
      for (int i = 0; i < SET_W; i++) begin
         set_msk[i] = (5'(i) < {1'b0, set_bits_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         block_ff <= block_in;
         set_ff   <= SET_W'(block_in) & set_msk;
      end
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // set memory, one row per set
   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         mem[clr_ff] <= '0;
      end else if (cmd.wr_en) begin
         mem[set_ff] <= row_new;
      end
      if (cmd.rd_en) begin
         row_ff <= mem[set_ff];
      end
   end

   // tag compare and empty search, lowest way wins
   always_comb begin
      hit_c     = 1'b0;
      hit_way_c = '0;
      emp_c     = 1'b0;
      emp_way_c = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (WC_W'(w) < ways_act) begin
            if (row_ff[w] && (row_ff[BLK_LO + w*ADDR_BITS +: ADDR_BITS] == block_ff)) begin
               hit_c     = 1'b1;
               hit_way_c = WAY_W'(w);
            end
            if (!row_ff[w]) begin
               emp_c     = 1'b1;
               emp_way_c = WAY_W'(w);
            end
         end
      end
   end

   // rotating victim pointer
   always_comb begin
      fifo_ptr   = row_ff[FIFO_LO +: WAY_W];
      fifo_way_c = (WC_W'(fifo_ptr) >= ways_act) ? '0 : fifo_ptr;
      fifo_nxt_c = ((WC_W'(fifo_way_c) + 1'b1) >= ways_act) ? '0 : fifo_way_c + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         hit_ff      <= hit_c;
         emp_ff      <= emp_c;
         hit_way_ff  <= hit_way_c;
         emp_way_ff  <= emp_way_c;
         fifo_way_ff <= fifo_way_c;
         fifo_nxt_ff <= fifo_nxt_c;
      end
   end

   // lru scan, one way a cycle, oldest stamp and lowest way on ties
   assign age = count_ff - row_ff[STP_LO + scan_ff*STAMP_W +: STAMP_W];

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         scan_ff     <= '0;
         best_age_ff <= '0;
         best_way_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + 1'b1;
         if (age > best_age_ff) begin
            best_age_ff <= age;
            best_way_ff <= scan_ff;
         end
      end
   end

   // way to update and the row written back
   always_comb begin
      if (hit_ff) begin
         way_sel = hit_way_ff;
      end else if (emp_ff) begin
         way_sel = emp_way_ff;
      end else if (policy_ff == sacl_pkg::POLICY_FIFO) begin
         way_sel = fifo_way_ff;
      end else begin
         way_sel = best_way_ff;
      end
      row_new = row_ff;
      row_new[way_sel] = 1'b1;
      row_new[BLK_LO + way_sel*ADDR_BITS +: ADDR_BITS] = block_ff;
      row_new[STP_LO + way_sel*STAMP_W +: STAMP_W]     = count_ff;
      if (!hit_ff && !emp_ff && (policy_ff == sacl_pkg::POLICY_FIFO)) begin
         row_new[FIFO_LO +: WAY_W] = fifo_nxt_ff;
      end
   end

   // access counter
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.wr_en) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.wr_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         rsp_hit          <= hit_ff;
         rsp_block_number <= block_ff;
         rsp_set_index    <= set_ff;
         rsp_way          <= way_sel;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // status to the controller
   always_comb begin
      sts.clr_last  = (clr_ff == SET_W'(MAX_SETS - 1));
      sts.need_scan = !hit_c && !emp_c && (policy_ff == sacl_pkg::POLICY_LRU);
      sts.scan_last = (WC_W'(scan_ff) == (ways_act - 1'b1));
      sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

endmodule

[hw/rtl/set_assoc_cache_lookup.sv]
// set_assoc_cache_lookup: one item in flight, result registered after the single-port set
// memory read, compare and write-back states on a hit, a fill or a fifo replacement, with
// the stamp scan (one way a cycle) between compare and write-back on an lru replacement; a
// new item is taken only once the last is written back, and a waiting result stalls the
// write-back. synchronous reset clears config to defaults, then a clearing pass over all
// MAX_SETS sets zeroes the set memory while no item is accepted.
module set_assoc_cache_lookup #(
   parameter int MAX_WAYS  = sacl_pkg::MAX_WAYS_DEF,
   parameter int MAX_SETS  = sacl_pkg::MAX_SETS_DEF,
   parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   sacl_req_if.sink                        req,
   sacl_rsp_if.source                      rsp,
   input  logic                            csr_we,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0] csr_wdata
);

   sacl_pkg::cmd_type cmd;
   sacl_pkg::sts_type sts;

   // controller
   sacl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   sacl_dp #(
      .MAX_WAYS  (MAX_WAYS),
      .MAX_SETS  (MAX_SETS),
      .ADDR_BITS (ADDR_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_address      (req.address),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_hit          (rsp.hit),
      .rsp_block_number (rsp.block_number),
      .rsp_set_index    (rsp.set_index),
      .rsp_way          (rsp.way)
   );

   assign req.ready = cmd.req_ready;

endmodule

[hw/rtl/sacl_chk.sv]
// port-level checker for the cache lookup and its bind
module sacl_chk #(
   parameter int MAX_WAYS  = sacl_pkg::MAX_WAYS_DEF,
   parameter int MAX_SETS  = sacl_pkg::MAX_SETS_DEF,
   parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF,
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
   localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_hit,
   input logic [ADDR_BITS-1:0] rsp_block_number,
   input logic [SET_W-1:0]     rsp_set_index,
   input logic [WAY_W-1:0]     rsp_way
);

   logic [1:0] pend_ff, pend_in;
   logic       acc, del;

   // items accepted and not yet delivered
   assign acc = req_valid && req_ready;
   assign del = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (acc && !del) pend_in = pend_ff + 2'd1;
      if (del && !acc) pend_in = pend_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_block_number) && $stable(rsp_set_index) && $stable(rsp_way))
      else $error("stalled result changed");

   // every result belongs to an accepted item
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without an accepted item");

   // at most one item in work plus one waiting result
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many items outstanding");

endmodule

bind set_assoc_cache_lookup sacl_chk #(
   .MAX_WAYS  (MAX_WAYS),
   .MAX_SETS  (MAX_SETS),
   .ADDR_BITS (ADDR_BITS)
) u_sacl_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_hit          (rsp.hit),
   .rsp_block_number (rsp.block_number),
   .rsp_set_index    (rsp.set_index),
   .rsp_way          (rsp.way)
);
